// File: design/gwr_pkg.sv
package gwr_pkg;

  localparam int MAX_LINE_DEF = 32;
  localparam int CFG_W = 6;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'd32;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 6'd32;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// File: design/gwr_if.sv
interface gwr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface gwr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       word_too_long;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output word_too_long,
                  output run_last, output text_done, input ready);
  modport sink (input valid, input out_byte, input word_too_long,
                input run_last, input text_done, output ready);
endinterface

// File: design/gwr_cell.sv
module gwr_cell (
  input  logic                clk,
  input  gwr_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          load_byte,
  input  logic [7:0]          next_byte,
  output logic [7:0]          data,
  output logic                is_space
);
  import gwr_pkg::*;

  // load the new character, or take the neighbor's byte as the line drains
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_byte;
    end else if (ctrl.shift) begin
      data <= next_byte;
    end
  end

  assign is_space = (data == SPACE_CHAR);
endmodule

// File: design/gwr_space_search.sv
module gwr_space_search #(
  parameter int DEPTH = 33,
  parameter int CW = 6
) (
  input  logic [DEPTH-1:0] space_flags,
  input  logic [CW-1:0]    limit,
  output logic             found,
  output logic [CW-1:0]    pos
);
  import gwr_pkg::*;

  // highest space at an index no greater than the limit
  always_comb begin
    found = 1'b0;
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (space_flags[i] && (CW'(i) <= limit)) begin
        found = 1'b1;
        pos = CW'(i);
      end
    end
  end
endmodule

// File: design/greedy_word_wrap_top.sv
// Channel   Dir  Payload                                         Handshake
// text_in   in   in_byte[7:0], end_of_text                       valid/ready
// text_out  out  out_byte[7:0], word_too_long, run_last,         valid/ready
//                text_done
// cfg       in   cfg_wdata[5:0] (line_limit)                     cfg_we
//
// A character that causes no break is loaded into the cell row in IDLE, and
// CHECK then compares the fill against the limit before the next is taken.
// A break runs the space search in CHECK, then BYTES emits the held bytes and
// NEWLN the newline as the cell row shifts toward the output register; a final
// flush emits each held byte from FLUSH. text_in is held off while a line drains.
// Output stalls freeze the cell row. Reset is synchronous; no clearing pass.
module greedy_word_wrap_top #(
  parameter int MAX_LINE = gwr_pkg::MAX_LINE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  gwr_in_if.sink                    text_in,
  gwr_out_if.source                 text_out,
  input  logic                      cfg_we,
  input  logic [gwr_pkg::CFG_W-1:0] cfg_wdata
);
  import gwr_pkg::*;

  localparam int DEPTH = MAX_LINE + 1;
  localparam int CW = $clog2(MAX_LINE + 2);
  localparam logic [CFG_W-1:0] MAX_LIM = CFG_W'(MAX_LINE);

  typedef enum logic [2:0] {IDLE, CHECK, BYTES, NEWLN, FLUSH} state_t;

  state_t state;
  logic [CFG_W-1:0] line_limit;
  logic [CW-1:0] fill;
  logic [CW-1:0] pos_cnt;
  logic last_r;
  logic discarding;

  logic o_valid;
  logic [7:0] o_byte;
  logic o_err;
  logic o_run_last;
  logic o_text_done;

  logic [CFG_W-1:0] lim6;
  logic [CW-1:0] lim;
  logic slot_free;
  logic accept;
  logic do_shift;
  logic emit;
  logic found;
  logic [CW-1:0] space_pos;
  logic [CW-1:0] fill_dec;

  logic [7:0] cell_data [DEPTH];
  logic [7:0] cell_next [DEPTH];
  logic [DEPTH-1:0] space_flags;
  cell_ctrl_t cell_ctrl [DEPTH];

  always_comb begin
    if (line_limit == '0) begin
      lim6 = CFG_W'(1);
    end else if (line_limit > MAX_LIM) begin
      lim6 = MAX_LIM;
    end else begin
      lim6 = line_limit;
    end
  end
  assign lim = CW'(lim6);

  assign slot_free = !o_valid || text_out.ready;
  assign text_in.ready = (state == IDLE);
  assign accept = text_in.valid && text_in.ready;
  assign do_shift = slot_free && (state == BYTES || state == NEWLN || state == FLUSH);
  // a new transaction enters the output register this cycle
  assign emit = do_shift || (slot_free && state == CHECK && fill > lim && !found);
  assign fill_dec = fill - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      line_limit <= cfg_wdata;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_end
      assign cell_next[g] = '0;
    end else begin : g_mid
      assign cell_next[g] = cell_data[g+1];
    end
    assign cell_ctrl[g].shift = do_shift;
    assign cell_ctrl[g].load = accept && !discarding && (fill == CW'(g));

    gwr_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .load_byte (text_in.in_byte),
      .next_byte (cell_next[g]),
      .data      (cell_data[g]),
      .is_space  (space_flags[g])
    );
  end

  gwr_space_search #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_search (
    .space_flags (space_flags),
    .limit       (lim),
    .found       (found),
    .pos         (space_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      fill <= '0;
      pos_cnt <= '0;
      last_r <= 1'b0;
      discarding <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      o_valid <= emit || (o_valid && !text_out.ready);
      case (state)
        IDLE: begin
          if (accept) begin
            if (discarding) begin
              if (text_in.end_of_text) begin
                discarding <= 1'b0;
              end
            end else begin
              fill <= fill + CW'(1);
              last_r <= text_in.end_of_text;
              state <= CHECK;
            end
          end
        end
        CHECK: begin
          if (fill > lim) begin
            if (!found) begin
              if (slot_free) begin
                o_byte <= '0;
                o_err <= 1'b1;
                o_run_last <= 1'b1;
                o_text_done <= last_r;
                fill <= '0;
                discarding <= !last_r;
                state <= IDLE;
              end
            end else begin
              pos_cnt <= space_pos;
              state <= (space_pos == '0) ? NEWLN : BYTES;
            end
          end else if (last_r && fill != '0) begin
            state <= FLUSH;
          end else begin
            state <= IDLE;
          end
        end
        BYTES: begin
          if (slot_free) begin
            o_byte <= cell_data[0];
            o_err <= 1'b0;
            o_run_last <= 1'b0;
            o_text_done <= 1'b0;
            fill <= fill_dec;
            pos_cnt <= pos_cnt - CW'(1);
            if (pos_cnt == CW'(1)) begin
              state <= NEWLN;
            end
          end
        end
        NEWLN: begin
          // drop the space; this newline ends the run unless more follows
          if (slot_free) begin
            o_byte <= NEWLINE_CHAR;
            o_err <= 1'b0;
            if (fill_dec > lim) begin
              o_run_last <= 1'b0;
              o_text_done <= 1'b0;
            end else begin
              o_run_last <= !last_r || (fill_dec == '0);
              o_text_done <= last_r && (fill_dec == '0);
            end
            fill <= fill_dec;
            state <= CHECK;
          end
        end
        FLUSH: begin
          if (slot_free) begin
            o_byte <= cell_data[0];
            o_err <= 1'b0;
            o_run_last <= (fill == CW'(1));
            o_text_done <= (fill == CW'(1));
            fill <= fill_dec;
            if (fill == CW'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign text_out.valid = o_valid;
  assign text_out.out_byte = o_byte;
  assign text_out.word_too_long = o_err;
  assign text_out.run_last = o_run_last;
  assign text_out.text_done = o_text_done;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("line store fill beyond depth");

  a_discard_empty: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (fill == '0))
    else $error("store not empty while discarding");

  a_bytes_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == BYTES) |-> (pos_cnt != '0 && pos_cnt < fill))
    else $error("break position outside held bytes");

  a_error_ends_run: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_err) |-> (o_run_last && o_byte == '0))
    else $error("error result malformed");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == FLUSH || state == NEWLN) |-> (fill != '0))
    else $error("drain from empty store");
endmodule

// File: bench/greedy_word_wrap_top_tb.sv
`timescale 1ns / 1ps

module greedy_word_wrap_top_tb;
  import gwr_pkg::*;

  localparam int MAX_LINE = MAX_LINE_DEF;
  localparam int RAND_ITEMS = 100;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic [7:0] out_byte;
    logic       word_too_long;
    logic       run_last;
    logic       text_done;
  } wrap_out_t;

  typedef struct {
    bit         set_limit;
    logic [5:0] limit;
    logic [7:0] ch;
    bit         eot;
    int         n_want;     // -1: left to the predictor
    bit         err_want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  gwr_in_if  text_in();
  gwr_out_if text_out();

  greedy_word_wrap_top #(.MAX_LINE(MAX_LINE)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .text_out (text_out),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Line-wrap predictor state
  logic [7:0] line_copy [0:MAX_LINE];
  int         line_fill;
  bit         skipping;
  logic [5:0] limit_reg;
  wrap_out_t  expected_chars[$];

  int fail_count = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int errors_seen = 0;
  int live_items = 0;
  int skipped_items = 0;
  int texts_sent = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  dir_row_t dir_rows[22] = '{
    '{1'b0, 6'd0,  "h",        1'b1, 1,  1'b0},
    '{1'b1, 6'd0,  "a",        1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  SPACE_CHAR, 1'b0, 2,  1'b0},
    '{1'b0, 6'd0,  SPACE_CHAR, 1'b0, 0,  1'b0},
    // space at the front of the line: bare newline
    '{1'b0, 6'd0,  "b",        1'b0, 1,  1'b0},
    '{1'b0, 6'd0,  "c",        1'b1, 1,  1'b1},
    '{1'b0, 6'd0,  "x",        1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  "y",        1'b0, 1,  1'b1},
    '{1'b0, 6'd0,  8'hff,      1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  8'h00,      1'b1, 0,  1'b0},
    '{1'b1, 6'd63, 8'hff,      1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  SPACE_CHAR, 1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  8'h00,      1'b1, 3,  1'b0},
    '{1'b1, 6'd32, "a",        1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  "b",        1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  SPACE_CHAR, 1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  "c",        1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  "d",        1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  SPACE_CHAR, 1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  "e",        1'b0, 0,  1'b0},
    '{1'b0, 6'd0,  "f",        1'b0, 0,  1'b0},
    // limit lowered mid-text: two breaks, then the tail word is too long
    '{1'b1, 6'd2,  "g",        1'b1, -1, 1'b0}
  };

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int eff_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > MAX_LINE) return MAX_LINE;
    return int'(limit_reg);
  endfunction

  function automatic void push_char(input logic [7:0] b, input logic err);
    wrap_out_t r;
    r.out_byte = b;
    r.word_too_long = err;
    r.run_last = 1'b0;
    r.text_done = 1'b0;
    expected_chars.push_back(r);
  endfunction

  // Apply one accepted byte; returns the number of results it causes.
  function automatic int wrap_predict(input logic [7:0] b, input bit eot);
    int lim;
    int pos;
    int drop;
    int start;
    int n;
    lim = eff_limit();
    start = expected_chars.size();
    if (skipping) begin
      if (eot) skipping = 1'b0;
      skipped_items++;
      return 0;
    end
    live_items++;
    if (line_fill < MAX_LINE + 1) begin
      line_copy[line_fill] = b;
      line_fill++;
    end
    while (line_fill > lim) begin
      pos = lim;
      while (pos >= 0 && line_copy[pos] != SPACE_CHAR) pos--;
      if (pos < 0) begin
        push_char(8'h00, 1'b1);
        line_fill = 0;
        skipping = !eot;
        break;
      end
      for (int i = 0; i < pos; i++) push_char(line_copy[i], 1'b0);
      push_char(NEWLINE_CHAR, 1'b0);
      drop = pos + 1;
      for (int i = 0; i < line_fill - drop; i++) line_copy[i] = line_copy[i + drop];
      line_fill -= drop;
    end
    if (eot && !(expected_chars.size() > start &&
                 expected_chars[expected_chars.size() - 1].word_too_long)) begin
      for (int i = 0; i < line_fill; i++) push_char(line_copy[i], 1'b0);
      line_fill = 0;
    end
    n = expected_chars.size() - start;
    if (n > 0) begin
      expected_chars[expected_chars.size() - 1].run_last = 1'b1;
      expected_chars[expected_chars.size() - 1].text_done = eot;
    end
    return n;
  endfunction

  task automatic wait_drain();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic send_text_byte(input logic [7:0] b, input bit eot, output int n_res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        text_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
    text_in.valid <= 1'b1;
    text_in.in_byte <= b;
    text_in.end_of_text <= eot;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    n_res = wrap_predict(b, eot);
  endtask

  // Write the limit only once the block has gone quiet.
  task automatic write_limit(input logic [5:0] v);
    text_in.valid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = v;
    burst_left = 0;
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(0, 255));
    else c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  function automatic logic [5:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd63;
      3: return 6'd32;
      4: return 6'($urandom_range(13, 31));
      default: return 6'($urandom_range(2, 12));
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    wrap_out_t want;
    if (!rst && text_out.valid && text_out.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h", text_out.out_byte));
      end else begin
        want = expected_chars.pop_front();
        results_seen++;
        if (want.word_too_long) errors_seen++;
        if (text_out.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    text_out.out_byte, want.out_byte));
        if (text_out.word_too_long !== want.word_too_long)
          report_mismatch($sformatf("word_too_long %b, want %b",
                                    text_out.word_too_long, want.word_too_long));
        if (text_out.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b",
                                    text_out.run_last, want.run_last));
        if (text_out.text_done !== want.text_done)
          report_mismatch($sformatf("text_done %b, want %b",
                                    text_out.text_done, want.text_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_chars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: stretches of full rate, random stalls and toggling, plus a long hold
  initial begin
    int stretch;
    int mode;
    int hold_cnt;
    text_out.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        text_out.ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_req = 1'b0;
      end else begin
        stretch = $urandom_range(1, 40);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < stretch && !hold_req; i++) begin
          case (mode)
            0: text_out.ready <= 1'b1;
            1: text_out.ready <= ($urandom_range(0, 9) < 6);
            default: text_out.ready <= i[0];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int n;
    int chg_at;
    int lim;
    int nwords;
    int wlen;
    logic [7:0] text_q[$];

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    text_in.valid <= 1'b0;
    text_in.in_byte <= '0;
    text_in.end_of_text <= 1'b0;
    line_fill = 0;
    skipping = 1'b0;
    limit_reg = LIMIT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_limit) write_limit(dir_rows[i].limit);
      send_text_byte(dir_rows[i].ch, dir_rows[i].eot, n);
      if (dir_rows[i].n_want >= 0 && n != dir_rows[i].n_want)
        report_mismatch($sformatf("row %0d: predictor gives %0d results, want %0d",
                                  i, n, dir_rows[i].n_want));
      if (dir_rows[i].err_want &&
          !(n > 0 && expected_chars[expected_chars.size() - 1].word_too_long))
        report_mismatch($sformatf("row %0d: no word-too-long result predicted", i));
    end
    texts_sent = 5;
    live_items = 0;

    while (live_items < RAND_ITEMS) begin
      // maybe change the limit, first pausing until everything is out
      if ($urandom_range(0, 1) == 0) write_limit(pick_limit());
      lim = eff_limit();
      text_q.delete();
      if (texts_sent == 7) begin
        hold_req = 1'b1;
        no_gaps = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 40);
        repeat (n) text_q.push_back(($urandom_range(0, 3) == 0) ? SPACE_CHAR :
                                    8'($urandom_range(0, 255)));
      end else begin
        nwords = no_gaps ? 16 : $urandom_range(1, 8);
        if ($urandom_range(0, 7) == 0) text_q.push_back(SPACE_CHAR);
        for (int w = 0; w < nwords; w++) begin
          if (w > 0) begin
            text_q.push_back(SPACE_CHAR);
            if ($urandom_range(0, 5) == 0) text_q.push_back(SPACE_CHAR);
          end
          if ($urandom_range(0, 11) == 0) wlen = lim + $urandom_range(1, 3);
          else if ($urandom_range(0, 4) == 0) wlen = $urandom_range(1, lim);
          else wlen = $urandom_range(1, (lim < 6) ? lim : 6);
          repeat (wlen) text_q.push_back(word_char());
        end
        if ($urandom_range(0, 7) == 0) text_q.push_back(SPACE_CHAR);
      end
      chg_at = ($urandom_range(0, 7) == 0 && text_q.size() > 2) ?
               $urandom_range(1, text_q.size() - 1) : -1;
      for (int k = 0; k < text_q.size(); k++) begin
        if (k == chg_at) write_limit(pick_limit());
        send_text_byte(text_q[k], k == text_q.size() - 1, n);
      end
      no_gaps = 1'b0;
      texts_sent++;
    end

    text_in.valid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d texts (%0d random bytes wrapped, %0d dropped while discarding)",
             texts_sent, live_items, skipped_items);
    $display("Checked %0d output characters, %0d of them word-too-long flags",
             results_seen, errors_seen);
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/gwr_pkg.sv
design/gwr_if.sv
design/gwr_cell.sv
design/gwr_space_search.sv
design/greedy_word_wrap_top.sv
bench/greedy_word_wrap_top_tb.sv
